// ----- hw/rtl/mpf_pkg.sv -----
// Package for the matrix power (Fibonacci) core.
// Field widths, default word width, shared control struct. No dependencies.
package mpf_pkg;

  localparam int FIELD_WIDTH    = 32;  // matrix entry and result field width
  localparam int EXP_WIDTH      = 31;  // exponent field width
  localparam int WORD_WIDTH_DEF = 32;  // default internal arithmetic width
  localparam int MAT_ENTRIES    = 4;   // 2x2 matrix, row-major

  // Control from the sequencer to the shared matrix multiply unit.
  typedef struct packed {
    logic load;     // capture the eight partial products
    logic sel_acc;  // left operand: 1 = accumulator, 0 = base
  } mpf_ctl_t;

endpackage : mpf_pkg

// ----- hw/rtl/mpf_matmul.sv -----
// Shared 2x2 matrix multiply unit: eight multipliers, registered products,
// four row-by-column sums. Depends on mpf_pkg.
module mpf_matmul
  import mpf_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  mpf_ctl_t              ctl,
  input  logic [WORD_WIDTH-1:0] acc   [MAT_ENTRIES],
  input  logic [WORD_WIDTH-1:0] base  [MAT_ENTRIES],
  output logic [WORD_WIDTH-1:0] sum   [MAT_ENTRIES]
);

  logic [WORD_WIDTH-1:0] x     [MAT_ENTRIES];
  logic [WORD_WIDTH-1:0] prod_r[2*MAT_ENTRIES];

  // Left operand is the accumulator or the base; right operand is always base.
  always_comb begin
    for (int i = 0; i < MAT_ENTRIES; i++) begin
      x[i] = ctl.sel_acc ? acc[i] : base[i];
    end
  end

  // Low word of each product; the low bits do not depend on signedness.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod_r[0] <= x[0] * base[0];
      prod_r[1] <= x[1] * base[2];
      prod_r[2] <= x[0] * base[1];
      prod_r[3] <= x[1] * base[3];
      prod_r[4] <= x[2] * base[0];
      prod_r[5] <= x[3] * base[2];
      prod_r[6] <= x[2] * base[1];
      prod_r[7] <= x[3] * base[3];
    end
  end

  always_comb begin
    for (int i = 0; i < MAT_ENTRIES; i++) begin
      sum[i] = prod_r[2*i] + prod_r[2*i+1];
    end
  end

endmodule : mpf_matmul

// ----- hw/rtl/matrix_power_fibonacci_core.sv -----
// Matrix power core: 2x2 matrix to a power by square-and-multiply, returns
// the top-right entry. Depends on mpf_pkg and mpf_matmul.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in_     | input     | in_valid/in_stall  | in_mat_00..in_mat_11, in_exponent
//  out_    | output    | out_valid/out_stall| out_power_top_right
//
// Each item runs B squarings, where B is the bit length of the exponent
//   minus one, and P accumulator products, where P is the count of set
//   bits; exponent zero runs neither. Each matrix product uses the one
//   shared unit of eight multipliers: products registered, then summed.
// in_stall is high from the accepting edge until the result sits in the
//   output register; the result waits there and the next item may enter.
// Reset (rst_n, synchronous, active low) clears the sequencer and out_valid.
module matrix_power_fibonacci_core
  import mpf_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [FIELD_WIDTH-1:0] in_mat_00,
  input  logic signed [FIELD_WIDTH-1:0] in_mat_01,
  input  logic signed [FIELD_WIDTH-1:0] in_mat_10,
  input  logic signed [FIELD_WIDTH-1:0] in_mat_11,
  input  logic        [EXP_WIDTH-1:0]   in_exponent,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [FIELD_WIDTH-1:0] out_power_top_right
);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MULA = 3'd1;  // products acc * base
  localparam logic [2:0] ST_SUMA = 3'd2;  // acc <= sums
  localparam logic [2:0] ST_MULB = 3'd3;  // products base * base
  localparam logic [2:0] ST_SUMB = 3'd4;  // base <= sums, next exponent bit
  localparam logic [2:0] ST_DONE = 3'd5;  // move result to output register

  logic [2:0]            state_r, state_nxt;
  logic [EXP_WIDTH-1:0]  exp_r, exp_nxt;
  logic [WORD_WIDTH-1:0] acc_r  [MAT_ENTRIES];
  logic [WORD_WIDTH-1:0] base_r [MAT_ENTRIES];
  logic [WORD_WIDTH-1:0] sum    [MAT_ENTRIES];
  logic                  out_valid_r, out_valid_nxt;
  logic signed [FIELD_WIDTH-1:0] out_data_r;
  logic                  in_xfer, out_xfer, out_free;
  mpf_ctl_t              ctl;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  assign out_valid           = out_valid_r;
  assign out_power_top_right = out_data_r;

  // Unit control: products captured in the multiply states.
  always_comb begin
    ctl.load    = (state_r == ST_MULA) || (state_r == ST_MULB);
    ctl.sel_acc = (state_r == ST_MULA);
  end

  mpf_matmul #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_matmul (
    .clk  (clk),
    .ctl  (ctl),
    .acc  (acc_r),
    .base (base_r),
    .sum  (sum)
  );

  // Sequencer. The exponent is scanned from bit 0; exp_r shifts right after
  // each squaring. The square after the top set bit is skipped.
  always_comb begin
    state_nxt     = state_r;
    exp_nxt       = exp_r;
    out_valid_nxt = out_valid_r && !out_xfer;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          exp_nxt = in_exponent;
          if (in_exponent == '0) begin
            state_nxt = ST_DONE;        // identity: result is zero
          end else if (in_exponent[0]) begin
            state_nxt = ST_MULA;
          end else begin
            state_nxt = ST_MULB;
          end
        end
      end
      ST_MULA: state_nxt = ST_SUMA;
      ST_SUMA: begin
        state_nxt = (exp_r[EXP_WIDTH-1:1] == '0) ? ST_DONE : ST_MULB;
      end
      ST_MULB: state_nxt = ST_SUMB;
      ST_SUMB: begin
        exp_nxt   = exp_r >> 1;
        state_nxt = exp_r[1] ? ST_MULA : ST_MULB;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers: no reset needed.
  always_ff @(posedge clk) begin
    exp_r <= exp_nxt;
    if (in_xfer) begin
      // entries are sign-extended or truncated to the word width
      base_r[0] <= WORD_WIDTH'(in_mat_00);
      base_r[1] <= WORD_WIDTH'(in_mat_01);
      base_r[2] <= WORD_WIDTH'(in_mat_10);
      base_r[3] <= WORD_WIDTH'(in_mat_11);
      acc_r[0]  <= WORD_WIDTH'(1);
      acc_r[1]  <= '0;
      acc_r[2]  <= '0;
      acc_r[3]  <= WORD_WIDTH'(1);
    end else if (state_r == ST_SUMA) begin
      acc_r <= sum;
    end else if (state_r == ST_SUMB) begin
      base_r <= sum;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_data_r <= FIELD_WIDTH'(signed'(acc_r[1]));
    end
  end

`ifndef NO_ASSERTIONS
  // An accepted item always starts the sequencer.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != ST_IDLE))
    else $error("sequencer did not leave idle after input transfer");

  // Accumulator products happen only for a set exponent bit.
  a_mula_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MULA) |-> exp_r[0])
    else $error("accumulator product on a clear exponent bit");

  // Accumulator products are always followed by their sums.
  a_mul_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MULA) |=> (state_r == ST_SUMA))
    else $error("product step not followed by sum step");

  // Squaring is only done while exponent bits remain above the current one.
  a_square_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MULB) |-> (exp_r[EXP_WIDTH-1:1] != '0))
    else $error("squaring with no higher exponent bits left");

  // The result register is loaded only when it is free.
  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && out_valid_r && out_stall) |=> (state_r == ST_DONE))
    else $error("sequencer left done while output was blocked");
`endif

endmodule : matrix_power_fibonacci_core

// ----- bench/matrix_power_fibonacci_core_tb.sv -----
// Self-checking bench for matrix_power_fibonacci_core: 2x2 matrix power, top-right entry.
// Depends on mpf_pkg and the core RTL. It holds its own square-and-multiply predictor.
// A clocked driver, a clocked monitor and a queue-fed stimulus block do the work.
module matrix_power_fibonacci_core_tb;
  import mpf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 9;
  localparam int PHASE_ITEMS  = 384;      // three random phases, about 1150 in all
  localparam int TAIL_CYCLES  = 300;      // longer than one worst-case item
  localparam int CYCLE_LIMIT  = 1000000;  // well above the slowest legal run

  localparam logic [FIELD_WIDTH-1:0] WORD_MIN = {1'b1, {(FIELD_WIDTH-1){1'b0}}};
  localparam logic [FIELD_WIDTH-1:0] WORD_MAX = {1'b0, {(FIELD_WIDTH-1){1'b1}}};
  localparam logic [FIELD_WIDTH-1:0] WORD_ONE = 1;
  localparam logic [EXP_WIDTH-1:0]   EXP_MAX  = '1;

  // One input transfer: the four matrix entries (row-major) and the exponent.
  typedef struct packed {
    logic [FIELD_WIDTH-1:0] m00;
    logic [FIELD_WIDTH-1:0] m01;
    logic [FIELD_WIDTH-1:0] m10;
    logic [FIELD_WIDTH-1:0] m11;
    logic [EXP_WIDTH-1:0]   power;
  } mat_item_t;

  // Row-major 2x2 matrix of 32-bit words; index 0 = row 0 col 0, 1 = row 0 col 1, ...
  typedef logic [MAT_ENTRIES-1:0][FIELD_WIDTH-1:0] mat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [FIELD_WIDTH-1:0] in_mat_00 = '0;
  logic signed [FIELD_WIDTH-1:0] in_mat_01 = '0;
  logic signed [FIELD_WIDTH-1:0] in_mat_10 = '0;
  logic signed [FIELD_WIDTH-1:0] in_mat_11 = '0;
  logic        [EXP_WIDTH-1:0]   in_exponent = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [FIELD_WIDTH-1:0] out_power_top_right;

  // Items waiting to be driven, and top-right entries owed by the core.
  mat_item_t              pending_items[$];
  logic [FIELD_WIDTH-1:0] owed_top_right[$];
  mat_item_t              shown_item;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int queued_count   = 0;
  int accepted_count = 0;
  int checked_count  = 0;
  int error_count    = 0;
  int cycle_count    = 0;

  matrix_power_fibonacci_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mat_00           (in_mat_00),
    .in_mat_01           (in_mat_01),
    .in_mat_10           (in_mat_10),
    .in_mat_11           (in_mat_11),
    .in_exponent         (in_exponent),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_power_top_right (out_power_top_right)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Predictor: 2x2 product wrapped to 32 bits, then square-and-multiply
  // from the exponent LSB with the accumulator starting at identity.
  // ------------------------------------------------------------------
  function automatic mat_t mat_product(mat_t x, mat_t y);
    mat_t p;
    p[0] = x[0] * y[0] + x[1] * y[2];
    p[1] = x[0] * y[1] + x[1] * y[3];
    p[2] = x[2] * y[0] + x[3] * y[2];
    p[3] = x[2] * y[1] + x[3] * y[3];
    return p;
  endfunction

  function automatic logic [FIELD_WIDTH-1:0] top_right_of_power(mat_item_t it);
    mat_t                 base;
    mat_t                 acc;
    logic [EXP_WIDTH-1:0] e;
    base = {it.m11, it.m10, it.m01, it.m00};
    acc  = {WORD_ONE, {FIELD_WIDTH{1'b0}}, {FIELD_WIDTH{1'b0}}, WORD_ONE};
    e    = it.power;
    while (e != '0) begin
      if (e[0]) acc = mat_product(acc, base);
      base = mat_product(base, base);
      e    = e >> 1;
    end
    // exponent zero leaves identity, so top-right is 0
    return acc[1];
  endfunction

  // ------------------------------------------------------------------
  // Driver: holds the payload until its transfer, never looks at
  // in_stall to decide valid, idles at send_idle_pct.
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        // push before counting so the end check never sees a half update
        owed_top_right.push_back(top_right_of_power(shown_item));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          shown_item  = pending_items.pop_front();
          in_mat_00   <= shown_item.m00;
          in_mat_01   <= shown_item.m01;
          in_mat_10   <= shown_item.m10;
          in_mat_11   <= shown_item.m11;
          in_exponent <= shown_item.power;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Monitor: checks each result transfer against the oldest owed value,
  // and stalls the result channel at recv_stall_pct.
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    logic [FIELD_WIDTH-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_top_right.size() == 0) begin
        $error("power_top_right: result with nothing expected, got %0d",
               out_power_top_right);
        error_count++;
      end else begin
        want = owed_top_right.pop_front();
        if (out_power_top_right !== want) begin
          $error("power_top_right: expected %0d, got %0d",
                 $signed(want), out_power_top_right);
          error_count++;
        end
        checked_count++;
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed",
               cycle_count, owed_top_right.size());
      $display("matrix_power_fibonacci_core regression: fail");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------
  function automatic logic [FIELD_WIDTH-1:0] pick_entry(int style);
    logic [FIELD_WIDTH-1:0] v;
    case (style)
      0: v = $urandom_range(8) - 4;               // small signed
      1: begin
        case ($urandom_range(4))
          0: v = '0;
          1: v = WORD_ONE;
          2: v = '1;
          3: v = WORD_MIN;
          default: v = WORD_MAX;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic mat_item_t random_item();
    mat_item_t it;
    int        style;
    int        sel;
    style = $urandom_range(99);
    if (style < 25) begin
      // Fibonacci matrix, the common use
      it.m00 = WORD_ONE; it.m01 = WORD_ONE; it.m10 = WORD_ONE; it.m11 = '0;
    end else begin
      sel    = (style < 50) ? 0 : (style < 65) ? 1 : 2;
      it.m00 = pick_entry(sel);
      it.m01 = pick_entry(sel);
      it.m10 = pick_entry(sel);
      it.m11 = pick_entry(sel);
    end
    sel = $urandom_range(99);
    if (sel < 30) begin
      it.power = EXP_WIDTH'($urandom_range(64));
    end else if (sel < 50) begin
      // random bit length, so the squaring count varies widely
      it.power = EXP_WIDTH'($urandom) & (EXP_MAX >> $urandom_range(EXP_WIDTH - 1));
    end else begin
      it.power = EXP_WIDTH'($urandom);
    end
    return it;
  endfunction

  task automatic queue_item(logic [FIELD_WIDTH-1:0] a, logic [FIELD_WIDTH-1:0] b,
                            logic [FIELD_WIDTH-1:0] c, logic [FIELD_WIDTH-1:0] d,
                            logic [EXP_WIDTH-1:0] p);
    mat_item_t it;
    it.m00 = a; it.m01 = b; it.m10 = c; it.m11 = d; it.power = p;
    pending_items.push_back(it);
    queued_count++;
  endtask

  // Sender pause: wait until every queued transfer is taken and every result is back.
  task automatic drain_all();
    while (accepted_count != queued_count || owed_top_right.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_random_phase(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      pending_items.push_back(random_item());
      queued_count++;
    end
    drain_all();
  endtask

  initial begin
    logic [FIELD_WIDTH-1:0] r0;
    logic [FIELD_WIDTH-1:0] r1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, light idling on both sides.
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    r0 = $urandom;
    r1 = $urandom;
    // Fibonacci matrix: zero exponent, tiny n, last n that fits, first that wraps
    queue_item(WORD_ONE, WORD_ONE, WORD_ONE, '0, EXP_WIDTH'(0));
    queue_item(WORD_ONE, WORD_ONE, WORD_ONE, '0, EXP_WIDTH'(1));
    queue_item(WORD_ONE, WORD_ONE, WORD_ONE, '0, EXP_WIDTH'(2));
    queue_item(WORD_ONE, WORD_ONE, WORD_ONE, '0, EXP_WIDTH'(10));
    queue_item(WORD_ONE, WORD_ONE, WORD_ONE, '0, EXP_WIDTH'(46));
    queue_item(WORD_ONE, WORD_ONE, WORD_ONE, '0, EXP_WIDTH'(47));
    queue_item(WORD_ONE, WORD_ONE, WORD_ONE, '0, EXP_MAX);
    // Extreme entries, products overflow hard
    queue_item(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, EXP_WIDTH'(1));
    queue_item(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, EXP_WIDTH'(3));
    queue_item(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, EXP_WIDTH'(2));
    queue_item('1, '1, '1, '1, EXP_WIDTH'(3));
    queue_item(WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN, EXP_WIDTH'(1) << (EXP_WIDTH - 1));
    queue_item('0, '0, '0, '0, EXP_MAX);
    queue_item('0, '0, '0, '0, EXP_WIDTH'(0));
    // Identity and permutation stay bounded under any power; diagonal keeps top-right zero
    queue_item(WORD_ONE, '0, '0, WORD_ONE, EXP_WIDTH'(12345));
    queue_item('0, WORD_ONE, WORD_ONE, '0, EXP_WIDTH'(5));
    queue_item('0, WORD_ONE, WORD_ONE, '0, EXP_WIDTH'(6));
    queue_item(2, '0, '0, 3, EXP_WIDTH'(31));
    // Random entries against alternating, full and zero exponents
    queue_item(r0, r1, r1, r0, 31'h2AAA_AAAA);
    queue_item(r1, r0, r0, r1, 31'h5555_5555);
    queue_item(r0, r1, ~r1, ~r0, EXP_MAX);
    queue_item(~r0, ~r1, r1, r0, EXP_WIDTH'(0));
    drain_all();

    // Random part: three idling mixes, each drained before the next.
    run_random_phase(31, 69);
    run_random_phase(69, 31);
    run_random_phase(0, 0);

    // Let any stray result show up before closing.
    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (owed_top_right.size() != 0) begin
      $error("power_top_right: %0d results never arrived", owed_top_right.size());
      error_count++;
    end

    $display("covered %0d matrix transfers (directed extremes, Fibonacci, random)",
             accepted_count);
    $display("checked %0d results under three stall mixes, %0d mismatches",
             checked_count, error_count);
    if (error_count == 0) begin
      $display("matrix_power_fibonacci_core regression: pass");
    end else begin
      $display("matrix_power_fibonacci_core regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/mpf_pkg.sv
hw/rtl/mpf_matmul.sv
hw/rtl/matrix_power_fibonacci_core.sv
bench/matrix_power_fibonacci_core_tb.sv
